// File: design/motor_encoder_alignment_sequencer_core_assert.svh
// Assertion macros shared by the alignment sequencer modules.
`ifndef MOTOR_ENCODER_ALIGNMENT_SEQUENCER_CORE_ASSERT_SVH
`define MOTOR_ENCODER_ALIGNMENT_SEQUENCER_CORE_ASSERT_SVH

// Condition that must hold in the same cycle as its antecedent.
`define MEAS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("alignment sequencer: same-cycle check failed");

// Condition that must hold in the cycle after its antecedent.
`define MEAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("alignment sequencer: next-cycle check failed");

`endif

// File: design/meas_pkg.sv
// Package with configuration types and register index codes of the alignment sequencer.
`timescale 1ns / 1ps
package meas_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int STEP_BITS      = 14;
   localparam int POLE_BITS      = 6;
   localparam int TICK_BITS      = 16;
   localparam int VOLT_BITS      = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_OPEN_LOOP_STEP = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_POLE_PAIRS     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MOVE_TICKS     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOCK_TICKS     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OPEN_LOOP_VQ   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOCK_VD        = 3'd5;

   typedef struct packed {
      logic [STEP_BITS-1:0] open_loop_step;
      logic [POLE_BITS-1:0] pole_pairs;
      logic [TICK_BITS-1:0] move_ticks;
      logic [TICK_BITS-1:0] lock_ticks;
      logic [VOLT_BITS-1:0] open_loop_vq_mv;
      logic [VOLT_BITS-1:0] lock_vd_mv;
   } cfg_type;

endpackage

// File: design/motor_encoder_alignment_sequencer_core.sv
// Top level of the motor encoder alignment sequencer: stream ports, input and result registers.
`timescale 1ns / 1ps
`include "motor_encoder_alignment_sequencer_core_assert.svh"
// The block runs the encoder offset alignment that a field-oriented motor drive needs at
// start-up. A request transaction with tuser high starts the sequence; every other request
// is a control tick carrying the raw encoder angle. The sequence drives an open-loop rotating
// q-axis voltage until the encoder reads inside the window, keeps rotating until its tick
// count passes move_ticks to decide the direction of rotation, then locks the rotor at
// electrical angle zero with a d-axis voltage until its tick count passes lock_ticks and
// records the electrical zero offset. Each request gives exactly one response transaction
// with the angle and voltage commands, the done flag, the direction and the offset. One
// request is accepted in every clock cycle while responses are taken. A request passes
// through the input register and then the result register, where its response is offered
// until taken. The pace of one transaction per cycle is set by the single add-and-multiply
// path that forms the electrical angle. The result register lets a new request in while the
// previous response is still waiting to be taken. The user must write the configuration
// registers through the csr port while no transaction is in flight; the block does not
// enforce this. The registers take effect on the next tick.
module motor_encoder_alignment_sequencer_core #(
   parameter int ANGLE_BITS   = 14,
   parameter int WINDOW_LIMIT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: encoder_angle
   input  logic [((ANGLE_BITS+7)/8)*8-1:0]     req_tdata,
   // tuser: action
   input  logic                                req_tuser,
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: done_res, angle_cmd, vd_cmd_mv, vq_cmd_mv, dir_negative, zero_offset
   output logic [((2*ANGLE_BITS+34+7)/8)*8-1:0] rsp_tdata,
   // tuser: drive_on
   output logic                                rsp_tuser,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [meas_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [meas_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import meas_pkg::*;

   localparam int RSP_DATA_BITS = ((2*ANGLE_BITS+34+7)/8)*8;

   cfg_type cfg;

   logic                  s1_valid_ff;
   logic                  s1_action_ff;
   logic [ANGLE_BITS-1:0] s1_enc_ff;
   logic                  out_ready, advance;

   logic                  seq_done, seq_drive, seq_dir;
   logic [ANGLE_BITS-1:0] seq_angle, seq_offset;
   logic [VOLT_BITS-1:0]  seq_vd, seq_vq;

   logic                  rsp_valid_ff;
   logic                  rsp_done_ff, rsp_drive_ff, rsp_dir_ff;
   logic [ANGLE_BITS-1:0] rsp_angle_ff, rsp_offset_ff;
   logic [VOLT_BITS-1:0]  rsp_vd_ff, rsp_vq_ff;

   logic                  rsp_quiet, rsp_cmds_zero, rsp_done_valid;

   // The result register is free when empty or when its transaction leaves this cycle.
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_ready;
   assign req_tready = !s1_valid_ff || out_ready;

   meas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_action_ff <= req_tuser;
         s1_enc_ff    <= req_tdata[ANGLE_BITS-1:0];
      end
   end

   meas_seq #(
      .ANGLE_BITS   (ANGLE_BITS),
      .WINDOW_LIMIT (WINDOW_LIMIT)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .action        (s1_action_ff),
      .encoder_angle (s1_enc_ff),
      .cfg           (cfg),
      .done_res      (seq_done),
      .drive_on      (seq_drive),
      .angle_cmd     (seq_angle),
      .vd_cmd_mv     (seq_vd),
      .vq_cmd_mv     (seq_vq),
      .dir_negative  (seq_dir),
      .zero_offset   (seq_offset)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_done_ff   <= seq_done;
         rsp_drive_ff  <= seq_drive;
         rsp_angle_ff  <= seq_angle;
         rsp_vd_ff     <= seq_vd;
         rsp_vq_ff     <= seq_vq;
         rsp_dir_ff    <= seq_dir;
         rsp_offset_ff <= seq_offset;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_drive_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_offset_ff, rsp_dir_ff, rsp_vq_ff, rsp_vd_ff,
                                       rsp_angle_ff, rsp_done_ff});

   // Terms of the checks below.
   assign rsp_quiet      = rsp_valid_ff && !rsp_drive_ff;
   assign rsp_cmds_zero  = (rsp_angle_ff == '0) && (rsp_vd_ff == '0) && (rsp_vq_ff == '0);
   assign rsp_done_valid = rsp_valid_ff && rsp_done_ff;

   `MEAS_ASSERT_IMPLIES(a_idle_cmds_zero, clock, reset, rsp_quiet, rsp_cmds_zero)
   `MEAS_ASSERT_IMPLIES(a_done_no_drive, clock, reset, rsp_done_valid, !rsp_drive_ff)
   `MEAS_ASSERT_IMPLIES(a_empty_takes_req, clock, reset, !rsp_valid_ff, req_tready)

endmodule

// File: design/meas_csr.sv
// Configuration register file of the alignment sequencer.
`timescale 1ns / 1ps
module meas_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [meas_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [meas_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output meas_pkg::cfg_type                    cfg
);
   import meas_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_loop_step  <= 14'd16;
         cfg_ff.pole_pairs      <= 6'd7;
         cfg_ff.move_ticks      <= 16'd1000;
         cfg_ff.lock_ticks      <= 16'd1000;
         cfg_ff.open_loop_vq_mv <= 16'd1000;
         cfg_ff.lock_vd_mv      <= 16'd1000;
      end else if (csr_valid) begin
         case (csr_index)
            REG_OPEN_LOOP_STEP: cfg_ff.open_loop_step  <= csr_data[STEP_BITS-1:0];
            REG_POLE_PAIRS:     cfg_ff.pole_pairs      <= csr_data[POLE_BITS-1:0];
            REG_MOVE_TICKS:     cfg_ff.move_ticks      <= csr_data;
            REG_LOCK_TICKS:     cfg_ff.lock_ticks      <= csr_data;
            REG_OPEN_LOOP_VQ:   cfg_ff.open_loop_vq_mv <= csr_data;
            REG_LOCK_VD:        cfg_ff.lock_vd_mv      <= csr_data;
            default: begin
            end
         endcase
      end
   end

endmodule

// File: design/meas_seq.sv
// Sequencer state and per-tick datapath of the alignment sequencer.
`timescale 1ns / 1ps
`include "motor_encoder_alignment_sequencer_core_assert.svh"
module meas_seq #(
   parameter int ANGLE_BITS   = 14,
   parameter int WINDOW_LIMIT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          action,
   input  logic [ANGLE_BITS-1:0]         encoder_angle,
   input  meas_pkg::cfg_type             cfg,
   output logic                          done_res,
   output logic                          drive_on,
   output logic [ANGLE_BITS-1:0]         angle_cmd,
   output logic [meas_pkg::VOLT_BITS-1:0] vd_cmd_mv,
   output logic [meas_pkg::VOLT_BITS-1:0] vq_cmd_mv,
   output logic                          dir_negative,
   output logic [ANGLE_BITS-1:0]         zero_offset
);
   import meas_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_PREP = 3'd1;
   localparam logic [2:0] PH_DIR  = 3'd2;
   localparam logic [2:0] PH_OFF  = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   localparam logic [ANGLE_BITS-1:0] ANGLE_HALF = ANGLE_BITS'(1 << (ANGLE_BITS - 1));

   logic [2:0]            phase_ff, phase_in;
   logic                  dir_sub_ff, dir_sub_in;
   logic                  off_sub_ff, off_sub_in;
   logic [16:0]           tick_ff, tick_in;
   logic [ANGLE_BITS-1:0] mech_ff, mech_in;
   logic [ANGLE_BITS-1:0] start_ff, start_in;
   logic                  dir_ff, dir_in;
   logic [ANGLE_BITS-1:0] offset_ff, offset_in;

   logic [STEP_BITS-1:0]    step_eff;
   logic [31:0]             step_wide;
   logic [ANGLE_BITS-1:0]   step_ab;
   logic [ANGLE_BITS-1:0]   adv1, adv2, diff;
   logic [16:0]             tick_inc;
   logic                    in_window, dir_path, sub_now, capture;
   logic [ANGLE_BITS+5:0]   product;
   logic [ANGLE_BITS-1:0]   elec;

   // A zero step would stall the open-loop drive, so it runs at one count.
   assign step_eff  = (cfg.open_loop_step == '0) ? STEP_BITS'(1) : cfg.open_loop_step;
   assign step_wide = {{(32-STEP_BITS){1'b0}}, step_eff};
   assign step_ab   = step_wide[ANGLE_BITS-1:0];
   assign adv1      = mech_ff + step_ab;
   assign adv2      = adv1 + step_ab;
   assign tick_inc  = tick_ff + 17'd1;
   assign diff      = encoder_angle - start_ff;
   assign in_window = (encoder_angle != '0) &&
                      ({{(32-ANGLE_BITS){1'b0}}, encoder_angle} < 32'(WINDOW_LIMIT));

   always_comb begin
      phase_in   = phase_ff;
      dir_sub_in = dir_sub_ff;
      off_sub_in = off_sub_ff;
      tick_in    = tick_ff;
      mech_in    = mech_ff;
      start_in   = start_ff;
      dir_in     = dir_ff;
      done_res   = 1'b0;
      drive_on   = 1'b0;
      vd_cmd_mv  = '0;
      vq_cmd_mv  = '0;
      dir_path   = 1'b0;
      sub_now    = dir_sub_ff;
      capture    = 1'b0;
      if (action) begin
         phase_in   = PH_PREP;
         dir_sub_in = 1'b0;
         off_sub_in = 1'b0;
         tick_in    = '0;
         mech_in    = '0;
      end else begin
         case (phase_ff)
            PH_PREP: begin
               drive_on  = 1'b1;
               vq_cmd_mv = cfg.open_loop_vq_mv;
               dir_path  = in_window;
               mech_in   = in_window ? adv2 : adv1;
               sub_now   = 1'b0;
            end
            PH_DIR: begin
               drive_on  = 1'b1;
               vq_cmd_mv = cfg.open_loop_vq_mv;
               dir_path  = 1'b1;
               mech_in   = adv1;
            end
            PH_OFF: begin
               drive_on  = 1'b1;
               vd_cmd_mv = cfg.lock_vd_mv;
               if (!off_sub_ff) begin
                  tick_in = tick_inc;
                  if (tick_inc > {1'b0, cfg.lock_ticks}) begin
                     capture    = 1'b1;
                     mech_in    = dir_ff ? ({ANGLE_BITS{1'b0}} - encoder_angle)
                                         : encoder_angle;
                     tick_in    = '0;
                     off_sub_in = 1'b1;
                     phase_in   = PH_DONE;
                  end
               end
            end
            default: begin
               done_res = 1'b1;
            end
         endcase
         // Direction phase work, also taken by a preparing tick that lands in the window.
         if (dir_path) begin
            if (!sub_now) begin
               phase_in   = PH_DIR;
               start_in   = encoder_angle;
               tick_in    = '0;
               dir_sub_in = 1'b1;
            end else begin
               tick_in = tick_inc;
               if (tick_inc > {1'b0, cfg.move_ticks}) begin
                  // Wrapped difference: an exact half turn keeps the sign of the raw one.
                  dir_in     = (encoder_angle >= start_ff) ? (diff > ANGLE_HALF)
                                                           : (diff >= ANGLE_HALF);
                  tick_in    = '0;
                  dir_sub_in = 1'b0;
                  off_sub_in = 1'b0;
                  phase_in   = PH_OFF;
               end
            end
         end
      end
   end

   assign product      = {6'b0, mech_in} * {{ANGLE_BITS{1'b0}}, cfg.pole_pairs};
   assign elec         = product[ANGLE_BITS-1:0];
   assign offset_in    = capture ? elec : offset_ff;
   assign angle_cmd    = dir_path || (!action && phase_ff == PH_PREP) ? elec : '0;
   assign dir_negative = dir_in;
   assign zero_offset  = offset_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         dir_sub_ff <= 1'b0;
         off_sub_ff <= 1'b0;
         tick_ff    <= '0;
         mech_ff    <= '0;
         start_ff   <= '0;
         dir_ff     <= 1'b0;
         offset_ff  <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         dir_sub_ff <= dir_sub_in;
         off_sub_ff <= off_sub_in;
         tick_ff    <= tick_in;
         mech_ff    <= mech_in;
         start_ff   <= start_in;
         dir_ff     <= dir_in;
         offset_ff  <= offset_in;
      end
   end

   `MEAS_ASSERT_NEXT(a_start_restarts, clock, reset, step && action, phase_ff == PH_PREP && tick_ff == '0)
   `MEAS_ASSERT_IMPLIES(a_done_after_lock, clock, reset, phase_ff == PH_DONE, off_sub_ff)
   `MEAS_ASSERT_NEXT(a_idle_holds, clock, reset, step && !action && phase_ff == PH_IDLE, phase_ff == PH_IDLE)

endmodule
